### rtl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants of the heap pool selector
// Field widths, word layouts, operation and status codes, and sequencer
// states used by the pool selection block.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int NUM_POOLS = 8;
    localparam int NUM_ROLES = 8;
    localparam int SIZE_BITS = 40;

    localparam int OP_W     = 2;
    localparam int SLOT_W   = 3;
    localparam int ID_W     = 32;
    localparam int ROLE_W   = 3;
    localparam int PRIO_W   = 8;
    localparam int ALIGN_W  = 33;
    localparam int SEL_W    = 32;
    localparam int STATUS_W = 3;

    // Request size plus alignment padding, and that sum plus bytes used.
    localparam int NEED_W = SIZE_BITS + 1;
    localparam int FIT_W  = SIZE_BITS + 2;

    // Load comparison runs on half-width partial products.
    localparam int HALF_W = (SIZE_BITS + 1) / 2;
    localparam int PROD_W = 2 * HALF_W;
    localparam int ACC_W  = 4 * HALF_W + 1;
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LOAD_ISSUE_LAST = STEP_W'(7);
    localparam logic [STEP_W-1:0] LOAD_ACC_LAST   = STEP_W'(8);
    localparam logic [STEP_W-1:0] LOAD_DECIDE     = STEP_W'(9);

    // Input word layout, lowest bit first.
    localparam int IN_SLOT_LSB   = 0;
    localparam int IN_TARGET_LSB = IN_SLOT_LSB + SLOT_W;
    localparam int IN_ROLE_LSB   = IN_TARGET_LSB + ID_W;
    localparam int IN_PRIO_LSB   = IN_ROLE_LSB + ROLE_W;
    localparam int IN_PLL_LSB    = IN_PRIO_LSB + PRIO_W;
    localparam int IN_GROW_LSB   = IN_PLL_LSB + 1;
    localparam int IN_CAP_LSB    = IN_GROW_LSB + 1;
    localparam int IN_USED_LSB   = IN_CAP_LSB + SIZE_BITS;
    localparam int IN_SIZE_LSB   = IN_USED_LSB + SIZE_BITS;
    localparam int IN_ALIGN_LSB  = IN_SIZE_LSB + SIZE_BITS;
    localparam int IN_NLL_LSB    = IN_ALIGN_LSB + ALIGN_W;
    localparam int IN_BITS       = IN_NLL_LSB + 1;
    localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

    // Output word layout, lowest bit first.
    localparam int OUT_BITS    = STATUS_W + SLOT_W + ID_W + SEL_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER,
        OP_REPORT,
        OP_UNREGISTER,
        OP_SELECT
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK,
        STS_INVALID,
        STS_SLOT_BUSY,
        STS_NO_CANDIDATE,
        STS_UNKNOWN_ID,
        STS_IN_USE,
        STS_IDS_EXHAUSTED
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_LOAD,
        ST_DONE
    } t_state;

endpackage

### rtl/heap_pool_selector_top.sv
// ----------------------------------------------------------------------------
// heap_pool_selector_top: memory pool table with best-pool selection
// Registers, reports, unregisters and selects pools over an eight-slot table
// with a small sequencer and one shared partial-product multiplier.
// ----------------------------------------------------------------------------
// Usage. Requests arrive as words on the slave stream: tuser carries the
// operation, tdata the request fields. Every request yields exactly one
// result word on the master stream. The block takes one request at a time
// and holds s_axis_tready low from acceptance until its result has been
// moved into the output register.
// Register, report usage and rejected requests pass from the check state
// straight to the done state. Tready rises together with the result.
// Unregister walks the slots, one per cycle, and stops at the match.
// Select walks all eight slots; each qualifying slot that ties the current
// best on priority and latency class runs a load comparison on the shared
// 20x20 multiplier (eight partial products, one per cycle, then a
// decision) before the scan moves on. The load comparison loop on that
// multiplier sets the worst case.
// Reset clears the slot valid bits, restarts identities at one and empties
// the output register; no clearing pass is needed. When the receiver stalls,
// the finished result waits in the output register, the next request can
// still be accepted, and its result waits in the sequencer until the
// output register frees.
// ----------------------------------------------------------------------------
module heap_pool_selector_top
    import hps_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // slot, target_id, role, priority_req, pool_low_latency, may_grow,
    // capacity, used_bytes, request_size, alignment, need_low_latency
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // operation
    input  logic [OP_W-1:0]        i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status, chosen_slot, pool_id, times_selected
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // Sequencer and request registers.
    t_state                r_state, n_state;
    t_op                   r_op;
    logic [SLOT_W-1:0]     r_slot;
    logic [ID_W-1:0]       r_target;
    logic [ROLE_W-1:0]     r_role;
    logic [PRIO_W-1:0]     r_prio;
    logic                  r_pll;
    logic                  r_grow;
    logic [SIZE_BITS-1:0]  r_cap;
    logic [SIZE_BITS-1:0]  r_used;
    logic                  r_size_zero;
    logic [ALIGN_W-1:0]    r_align;
    logic [NEED_W-1:0]     r_need;
    logic                  r_need_ll;

    // Pool table. Only the valid bits are reset.
    logic [NUM_POOLS-1:0]  r_valid;
    logic [ID_W-1:0]       r_tab_id   [NUM_POOLS];
    logic [ROLE_W-1:0]     r_tab_role [NUM_POOLS];
    logic [PRIO_W-1:0]     r_tab_prio [NUM_POOLS];
    logic                  r_tab_ll   [NUM_POOLS];
    logic                  r_tab_grow [NUM_POOLS];
    logic [SIZE_BITS-1:0]  r_tab_cap  [NUM_POOLS];
    logic [SIZE_BITS-1:0]  r_tab_used [NUM_POOLS];
    logic [SEL_W-1:0]      r_tab_sel  [NUM_POOLS];
    logic [ID_W-1:0]       r_next_id;

    // Scan position and the best candidate seen so far.
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic                  r_have_best, n_have_best;
    logic [SLOT_W-1:0]     r_best_slot;
    logic [ID_W-1:0]       r_best_id;
    logic [PRIO_W-1:0]     r_best_prio;
    logic                  r_best_ll;
    logic [SIZE_BITS-1:0]  r_best_n;
    logic [SIZE_BITS-1:0]  r_best_d;
    logic [SEL_W-1:0]      r_best_sel;

    // Shared multiplier and load difference accumulator.
    logic [STEP_W-1:0]     r_step, n_step;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic                  r_prod_sub, n_prod_sub;
    logic [1:0]            r_prod_pos, n_prod_pos;
    logic [ACC_W-1:0]      r_acc, n_acc;

    // Result of the current request.
    t_status               r_status, n_status;
    logic [SLOT_W-1:0]     r_res_slot, n_res_slot;
    logic [ID_W-1:0]       r_res_id, n_res_id;
    logic [SEL_W-1:0]      r_res_times, n_res_times;

    // Output register.
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // Combinational control.
    logic                  accept;
    logic                  out_free;
    logic                  done_fire;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  rd_valid;
    logic [ID_W-1:0]       rd_id;
    logic [ROLE_W-1:0]     rd_role;
    logic [PRIO_W-1:0]     rd_prio;
    logic                  rd_ll;
    logic                  rd_grow;
    logic [SIZE_BITS-1:0]  rd_cap;
    logic [SIZE_BITS-1:0]  rd_used;
    logic [SEL_W-1:0]      rd_sel;
    logic [SIZE_BITS-1:0]  cand_n;
    logic [SIZE_BITS-1:0]  cand_d;
    logic                  cand_fit;
    logic                  cand_qual;
    logic                  tie;
    logic                  rank_direct;
    logic                  scan_last;
    logic                  load_decide;
    logic                  load_take;
    logic                  take;
    logic                  start_load;
    logic                  match_unreg;
    logic                  role_bad;
    logic                  select_bad;
    logic [SEL_W-1:0]      best_sel_inc;
    logic [SIZE_BITS-1:0]  mul_x;
    logic [SIZE_BITS-1:0]  mul_y;
    logic [HALF_W-1:0]     mul_xh;
    logic [HALF_W-1:0]     mul_yh;
    logic [ACC_W-1:0]      acc_term;
    logic [SLOT_W-1:0]     wr_addr;
    logic                  wr_enable;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign done_fire       = (r_state == ST_DONE) && out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Single table read port: the addressed slot while checking, else the scan slot.
    assign rd_addr  = (r_state == ST_CHECK) ? r_slot : r_idx;
    assign rd_valid = r_valid[rd_addr];
    assign rd_id    = r_tab_id[rd_addr];
    assign rd_role  = r_tab_role[rd_addr];
    assign rd_prio  = r_tab_prio[rd_addr];
    assign rd_ll    = r_tab_ll[rd_addr];
    assign rd_grow  = r_tab_grow[rd_addr];
    assign rd_cap   = r_tab_cap[rd_addr];
    assign rd_used  = r_tab_used[rd_addr];
    assign rd_sel   = r_tab_sel[rd_addr];

    // A pool of zero capacity counts as fully loaded, i.e. load one over one.
    assign cand_n = (rd_cap == '0) ? SIZE_BITS'(1) : rd_used;
    assign cand_d = (rd_cap == '0) ? SIZE_BITS'(1) : rd_cap;

    // The request fits when used plus size plus padding stays within capacity.
    assign cand_fit  = (FIT_W'(rd_used) + FIT_W'(r_need)) <= FIT_W'(rd_cap);
    assign cand_qual = rd_valid && (rd_role == r_role) && (!r_need_ll || rd_ll)
                       && (rd_grow || cand_fit);

    assign tie         = (rd_prio == r_best_prio) && (rd_ll == r_best_ll);
    assign rank_direct = (rd_prio != r_best_prio) ? (rd_prio > r_best_prio) : rd_ll;
    assign scan_last   = (r_idx == SLOT_W'(NUM_POOLS - 1));
    assign load_decide = (r_state == ST_LOAD) && (r_step == LOAD_DECIDE);

    // The accumulator holds cand_n*best_d - best_n*cand_d: negative means the
    // candidate carries the lower load.
    assign load_take = r_acc[ACC_W-1] || ((r_acc == '0) && (rd_id < r_best_id));

    assign start_load  = (r_state == ST_SCAN) && (r_op == OP_SELECT) && cand_qual
                         && r_have_best && tie;
    assign take        = ((r_state == ST_SCAN) && (r_op == OP_SELECT) && cand_qual
                          && (!r_have_best || (!tie && rank_direct)))
                         || (load_decide && load_take);
    assign match_unreg = (r_state == ST_SCAN) && (r_op == OP_UNREGISTER) && rd_valid
                         && (rd_id == r_target);

    assign role_bad   = (ROLE_W + 1)'(r_role) >= (ROLE_W + 1)'(NUM_ROLES);
    assign select_bad = role_bad || r_size_zero || (r_align == '0)
                        || ((r_align & (r_align - ALIGN_W'(1))) != '0);

    assign best_sel_inc = (r_best_sel == '1) ? r_best_sel : r_best_sel + SEL_W'(1);

    // Operand selection of the shared multiplier. Steps 0 to 3 form
    // cand_n*best_d, steps 4 to 7 best_n*cand_d, one half pair per step.
    assign mul_x  = r_step[2] ? r_best_n : cand_n;
    assign mul_y  = r_step[2] ? cand_d : r_best_d;
    assign mul_xh = r_step[1] ? HALF_W'(mul_x >> HALF_W) : mul_x[HALF_W-1:0];
    assign mul_yh = r_step[0] ? HALF_W'(mul_y >> HALF_W) : mul_y[HALF_W-1:0];

    always_comb begin
        case (r_prod_pos)
            2'd0:    acc_term = ACC_W'(r_prod);
            2'd1:    acc_term = ACC_W'(r_prod) << HALF_W;
            default: acc_term = ACC_W'(r_prod) << (2 * HALF_W);
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if ((r_op == OP_UNREGISTER) && (r_target != '0)) begin
                    n_state = ST_SCAN;
                end else if ((r_op == OP_SELECT) && !select_bad) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (start_load) begin
                    n_state = ST_LOAD;
                end else if (match_unreg || scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_LOAD: begin
                if (load_decide) begin
                    n_state = scan_last ? ST_DONE : ST_SCAN;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and result control.
    always_comb begin
        n_idx       = r_idx;
        n_have_best = r_have_best;
        n_step      = r_step;
        n_prod      = r_prod;
        n_prod_sub  = r_prod_sub;
        n_prod_pos  = r_prod_pos;
        n_acc       = r_acc;
        n_status    = r_status;
        n_res_slot  = r_res_slot;
        n_res_id    = r_res_id;
        n_res_times = r_res_times;
        n_out_data  = '0;
        wr_enable   = 1'b0;
        wr_addr     = (r_op == OP_SELECT) ? r_best_slot : r_res_slot;

        case (r_state)
            ST_CHECK: begin
                n_idx       = '0;
                n_have_best = 1'b0;
                n_status    = STS_OK;
                n_res_slot  = '0;
                n_res_id    = '0;
                n_res_times = '0;
                case (r_op)
                    OP_REGISTER: begin
                        if (((SLOT_W + 1)'(r_slot) >= (SLOT_W + 1)'(NUM_POOLS)) || role_bad
                            || (r_cap == '0)) begin
                            n_status = STS_INVALID;
                        end else if (rd_valid) begin
                            n_status = STS_SLOT_BUSY;
                        end else if (r_next_id == '0) begin
                            n_status = STS_IDS_EXHAUSTED;
                        end else begin
                            n_res_slot = r_slot;
                            n_res_id   = r_next_id;
                        end
                    end
                    OP_REPORT: begin
                        if (((SLOT_W + 1)'(r_slot) >= (SLOT_W + 1)'(NUM_POOLS)) || !rd_valid)
                        begin
                            n_status = STS_INVALID;
                        end else begin
                            n_res_slot  = r_slot;
                            n_res_id    = rd_id;
                            n_res_times = rd_sel;
                        end
                    end
                    OP_UNREGISTER: begin
                        if (r_target == '0) begin
                            n_status = STS_INVALID;
                        end
                    end
                    default: begin
                        if (select_bad) begin
                            n_status = STS_INVALID;
                        end
                    end
                endcase
            end
            ST_SCAN: begin
                if (take) begin
                    n_have_best = 1'b1;
                end
                if (match_unreg) begin
                    n_res_slot = r_idx;
                    n_res_id   = r_target;
                    n_status   = (rd_used != '0) ? STS_IN_USE : STS_OK;
                end else if (start_load) begin
                    n_step = '0;
                    n_acc  = '0;
                end else if (scan_last) begin
                    if (r_op == OP_UNREGISTER) begin
                        n_status = STS_UNKNOWN_ID;
                    end else begin
                        n_status = (take || r_have_best) ? STS_OK : STS_NO_CANDIDATE;
                    end
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            ST_LOAD: begin
                n_step = r_step + STEP_W'(1);
                if (r_step <= LOAD_ISSUE_LAST) begin
                    n_prod     = PROD_W'(mul_xh) * PROD_W'(mul_yh);
                    n_prod_sub = r_step[2];
                    n_prod_pos = 2'(r_step[1]) + 2'(r_step[0]);
                end
                if ((r_step != '0) && (r_step <= LOAD_ACC_LAST)) begin
                    n_acc = r_prod_sub ? (r_acc - acc_term) : (r_acc + acc_term);
                end
                if (load_decide) begin
                    if (scan_last) begin
                        n_status = STS_OK;
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
            end
            ST_DONE: begin
                wr_enable = done_fire && (r_status == STS_OK);
                n_out_data[STATUS_W-1:0] = r_status;
                if (r_status == STS_OK) begin
                    if (r_op == OP_SELECT) begin
                        n_out_data[STATUS_W +: SLOT_W]                 = r_best_slot;
                        n_out_data[STATUS_W + SLOT_W +: ID_W]          = r_best_id;
                        n_out_data[STATUS_W + SLOT_W + ID_W +: SEL_W]  = best_sel_inc;
                    end else begin
                        n_out_data[STATUS_W +: SLOT_W]                 = r_res_slot;
                        n_out_data[STATUS_W + SLOT_W +: ID_W]          = r_res_id;
                        n_out_data[STATUS_W + SLOT_W + ID_W +: SEL_W]  = r_res_times;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_next_id   <= ID_W'(1);
            r_out_valid <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have_best <= n_have_best;
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_enable && (r_op == OP_REGISTER)) begin
                r_valid[wr_addr] <= 1'b1;
                r_next_id        <= r_next_id + ID_W'(1);
            end else if (wr_enable && (r_op == OP_UNREGISTER)) begin
                r_valid[wr_addr] <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op        <= t_op'(i_s_axis_tuser);
            r_slot      <= i_s_axis_tdata[IN_SLOT_LSB +: SLOT_W];
            r_target    <= i_s_axis_tdata[IN_TARGET_LSB +: ID_W];
            r_role      <= i_s_axis_tdata[IN_ROLE_LSB +: ROLE_W];
            r_prio      <= i_s_axis_tdata[IN_PRIO_LSB +: PRIO_W];
            r_pll       <= i_s_axis_tdata[IN_PLL_LSB];
            r_grow      <= i_s_axis_tdata[IN_GROW_LSB];
            r_cap       <= i_s_axis_tdata[IN_CAP_LSB +: SIZE_BITS];
            r_used      <= i_s_axis_tdata[IN_USED_LSB +: SIZE_BITS];
            r_size_zero <= (i_s_axis_tdata[IN_SIZE_LSB +: SIZE_BITS] == '0);
            r_align     <= i_s_axis_tdata[IN_ALIGN_LSB +: ALIGN_W];
            r_need      <= NEED_W'(i_s_axis_tdata[IN_SIZE_LSB +: SIZE_BITS])
                           + NEED_W'(i_s_axis_tdata[IN_ALIGN_LSB +: ALIGN_W] - ALIGN_W'(1));
            r_need_ll   <= i_s_axis_tdata[IN_NLL_LSB];
        end

        r_idx       <= n_idx;
        r_step      <= n_step;
        r_prod      <= n_prod;
        r_prod_sub  <= n_prod_sub;
        r_prod_pos  <= n_prod_pos;
        r_acc       <= n_acc;
        r_status    <= n_status;
        r_res_slot  <= n_res_slot;
        r_res_id    <= n_res_id;
        r_res_times <= n_res_times;

        if (take) begin
            r_best_slot <= r_idx;
            r_best_id   <= rd_id;
            r_best_prio <= rd_prio;
            r_best_ll   <= rd_ll;
            r_best_n    <= cand_n;
            r_best_d    <= cand_d;
            r_best_sel  <= rd_sel;
        end

        if (done_fire) begin
            r_out_data <= n_out_data;
        end

        if (wr_enable) begin
            case (r_op)
                OP_REGISTER: begin
                    r_tab_id[wr_addr]   <= r_next_id;
                    r_tab_role[wr_addr] <= r_role;
                    r_tab_prio[wr_addr] <= r_prio;
                    r_tab_ll[wr_addr]   <= r_pll;
                    r_tab_grow[wr_addr] <= r_grow;
                    r_tab_cap[wr_addr]  <= r_cap;
                    r_tab_used[wr_addr] <= r_used;
                    r_tab_sel[wr_addr]  <= '0;
                end
                OP_REPORT: begin
                    r_tab_cap[wr_addr]  <= r_cap;
                    r_tab_used[wr_addr] <= r_used;
                end
                OP_SELECT: begin
                    r_tab_sel[wr_addr]  <= best_sel_inc;
                end
                default: begin
                end
            endcase
        end
    end

    // A failed request reports nothing but its status.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[STATUS_W-1:0] != STS_OK))
        |-> (o_m_axis_tdata[OUT_TDATA_W-1:STATUS_W] == '0))
        else $error("failed request carries nonzero result fields");

    // Every successful result names an identity, never zero.
    a_ok_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[STATUS_W-1:0] == STS_OK))
        |-> (o_m_axis_tdata[STATUS_W + SLOT_W +: ID_W] != '0))
        else $error("successful result with identity zero");

    // The load comparison never runs past its decision step.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> (r_step <= LOAD_DECIDE))
        else $error("load comparison step counter overran");

    // An accepted word is always checked in the following cycle.
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_CHECK))
        else $error("accepted word not checked");

endmodule
